// ----- design/vnsl_pkg.sv -----
// Package for the nearest-seed labeler: sizes, register indexes, queue item type.
// Used by vnsl_front, vnsl_back and voronoi_nearest_seed_labeler_core. No dependencies.
package vnsl_pkg;

	localparam int MAX_SEED_ENTRIES = 64;
	localparam int IMAGE_DIM        = 1024;

	// field widths
	localparam int SEED_IDX_W = 6;
	localparam int POS_W      = 16;
	localparam int PIX_W      = 10;
	localparam int FRAC_W     = 6;
	localparam int COUNT_W    = 7;
	localparam int LABEL_W    = 6;

	// table addressing and search counter
	localparam int TBL_AW = $clog2(MAX_SEED_ENTRIES);
	localparam int CNT_W  = $clog2(MAX_SEED_ENTRIES + 1);

	// distance widths
	localparam int SQ_W   = 2 * POS_W;
	localparam int DIST_W = SQ_W + 1;

	// stream widths
	localparam int S_TDATA_W = 64;
	localparam int M_TDATA_W = 8;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// configuration registers
	localparam int APB_AW   = 3;
	localparam logic REG_METRIC = 1'b0;
	localparam logic REG_COUNT  = 1'b1;
	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(25);

	// metric codes
	localparam logic METRIC_EUCLID    = 1'b0;
	localparam logic METRIC_MANHATTAN = 1'b1;

	// input mode codes
	localparam logic MODE_WRITE    = 1'b0;
	localparam logic MODE_CLASSIFY = 1'b1;

	typedef enum logic [1:0] {
		KIND_WRITE    = 2'd0,
		KIND_CLASSIFY = 2'd1,
		KIND_SKIP     = 2'd2
	} item_kind_t;

	typedef struct packed {
		item_kind_t              kind;
		logic [TBL_AW-1:0]       seed_addr;
		logic [POS_W-1:0]        seed_y;
		logic [POS_W-1:0]        seed_x;
		logic [PIX_W-1:0]        pixel_y;
		logic [PIX_W-1:0]        pixel_x;
	} queue_item_t;

endpackage

// ----- design/vnsl_front.sv -----
// Front end: accepts stream items, decodes them and buffers them in a short queue.
// Depends on vnsl_pkg.
module vnsl_front
	import vnsl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// seed_index[5:0], seed_pos_x[21:6], seed_pos_y[37:22], pixel_x[47:38],
	// pixel_y[57:48], zero [63:58]
	input  logic [S_TDATA_W-1:0] s_tdata,
	// mode[0]
	input  logic                 s_tuser,
	output logic                 q_valid,
	output queue_item_t          q_item,
	input  logic                 q_pop
);

	logic [SEED_IDX_W-1:0] in_index;
	logic [POS_W-1:0]      in_sx;
	logic [POS_W-1:0]      in_sy;
	logic [PIX_W-1:0]      in_px;
	logic [PIX_W-1:0]      in_py;
	queue_item_t           dec_item;

	queue_item_t           q_mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]     wr_ptr_q;
	logic [QPTR_W-1:0]     rd_ptr_q;
	logic [QPTR_W:0]       count_q;
	logic                  push;

	assign in_index = s_tdata[SEED_IDX_W-1:0];
	assign in_sx    = s_tdata[SEED_IDX_W +: POS_W];
	assign in_sy    = s_tdata[SEED_IDX_W + POS_W +: POS_W];
	assign in_px    = s_tdata[SEED_IDX_W + 2*POS_W +: PIX_W];
	assign in_py    = s_tdata[SEED_IDX_W + 2*POS_W + PIX_W +: PIX_W];

	// Decode: drop out-of-table writes, clamp pixels to the image
	always_comb begin
		dec_item.seed_addr = in_index[TBL_AW-1:0];
		dec_item.seed_x    = in_sx;
		dec_item.seed_y    = in_sy;
		dec_item.pixel_x   = ({1'b0, in_px} >= (PIX_W+1)'(IMAGE_DIM)) ?
			PIX_W'(IMAGE_DIM - 1) : in_px;
		dec_item.pixel_y   = ({1'b0, in_py} >= (PIX_W+1)'(IMAGE_DIM)) ?
			PIX_W'(IMAGE_DIM - 1) : in_py;
		if (s_tuser == MODE_CLASSIFY) begin
			dec_item.kind = KIND_CLASSIFY;
		end else if ({1'b0, in_index} < (SEED_IDX_W+1)'(MAX_SEED_ENTRIES)) begin
			dec_item.kind = KIND_WRITE;
		end else begin
			dec_item.kind = KIND_SKIP;
		end
	end

	assign s_tready = (count_q < (QPTR_W+1)'(QUEUE_DEPTH));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != '0);
	assign q_item   = q_mem_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= dec_item;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !q_pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (!push && q_pop) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

// ----- design/vnsl_back.sv -----
// Back end: seed table memory, one-seed-per-cycle distance pipeline, result register.
// Depends on vnsl_pkg.
module vnsl_back
	import vnsl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 metric_select,
	input  logic [COUNT_W-1:0]   seed_count,
	input  logic                 q_valid,
	input  queue_item_t          q_item,
	output logic                 q_pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [LABEL_W-1:0]   m_label
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_DONE = 3'b100
	} back_state_t;

	back_state_t          state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     n_q;
	logic [POS_W-1:0]     px_q;
	logic [POS_W-1:0]     py_q;
	logic                 metric_q;
	logic                 have_q;
	logic [DIST_W-1:0]    best_q;
	logic [TBL_AW-1:0]    label_q;

	logic [SQ_W-1:0]      mem [MAX_SEED_ENTRIES];

	logic                 issue;
	logic                 v_s1, v_s2, v_s3;
	logic [TBL_AW-1:0]    idx_s1, idx_s2, idx_s3;
	logic [SQ_W-1:0]      rdata_s1;
	logic [POS_W-1:0]     dx_s2, dy_s2;
	logic [SQ_W-1:0]      a_s3, b_s3;

	logic [POS_W-1:0]     sx, sy;
	logic [POS_W-1:0]     dx, dy;
	logic [DIST_W-1:0]    dist_sum;
	logic [CNT_W-1:0]     n_clip;
	logic                 start;
	logic                 out_load;
	logic                 out_valid_q;
	logic [LABEL_W-1:0]   out_label_q;

	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign start    = q_pop && (q_item.kind == KIND_CLASSIFY);
	assign issue    = (state_q == ST_WALK) && (cnt_q < n_q);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_tready);
	assign n_clip   = ({1'b0, seed_count} > (COUNT_W+1)'(MAX_SEED_ENTRIES)) ?
		CNT_W'(MAX_SEED_ENTRIES) : CNT_W'(seed_count);

	// Seed table: write on a popped write item
	always_ff @(posedge clk) begin
		if (q_pop && (q_item.kind == KIND_WRITE)) begin
			mem[q_item.seed_addr] <= {q_item.seed_y, q_item.seed_x};
		end
	end

	// Stage 1: registered table read
	always_ff @(posedge clk) begin
		rdata_s1 <= mem[cnt_q[TBL_AW-1:0]];
		idx_s1   <= cnt_q[TBL_AW-1:0];
	end

	// Stage 2: absolute coordinate differences
	assign sx = rdata_s1[POS_W-1:0];
	assign sy = rdata_s1[SQ_W-1:POS_W];
	assign dx = (px_q >= sx) ? (px_q - sx) : (sx - px_q);
	assign dy = (py_q >= sy) ? (py_q - sy) : (sy - py_q);

	always_ff @(posedge clk) begin
		dx_s2  <= dx;
		dy_s2  <= dy;
		idx_s2 <= idx_s1;
	end

	// Stage 3: squares or plain differences
	always_ff @(posedge clk) begin
		if (metric_q == METRIC_EUCLID) begin
			a_s3 <= dx_s2 * dx_s2;
			b_s3 <= dy_s2 * dy_s2;
		end else begin
			a_s3 <= SQ_W'(dx_s2);
			b_s3 <= SQ_W'(dy_s2);
		end
		idx_s3 <= idx_s2;
	end

	// Stage 4: sum and strict compare against the running best
	assign dist_sum = {1'b0, a_s3} + {1'b0, b_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Search control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			n_q     <= '0;
			have_q  <= 1'b0;
			label_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_WALK;
						cnt_q   <= '0;
						n_q     <= n_clip;
						have_q  <= 1'b0;
						label_q <= '0;
					end
				end
				ST_WALK: begin
					if (issue) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end else if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= ST_DONE;
					end
					if (v_s3 && (!have_q || (dist_sum < best_q))) begin
						have_q  <= 1'b1;
						label_q <= idx_s3;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Best distance and pixel latches
	always_ff @(posedge clk) begin
		if (start) begin
			px_q     <= {q_item.pixel_x, FRAC_W'(0)};
			py_q     <= {q_item.pixel_y, FRAC_W'(0)};
			metric_q <= metric_select;
		end
		if ((state_q == ST_WALK) && v_s3 && (!have_q || (dist_sum < best_q))) begin
			best_q <= dist_sum;
		end
	end

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_label_q <= LABEL_W'(label_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_label  = out_label_q;

endmodule

// ----- design/voronoi_nearest_seed_labeler_core.sv -----
// Top level of the nearest-seed labeler: configuration registers, front and back.
// Depends on vnsl_pkg, vnsl_front and vnsl_back.
//
//   port group   direction  payload                         handshake
//   s_*          in         tdata: seed/pixel, tuser: mode  tvalid & tready
//   m_*          out        tdata: nearest_label            tvalid & tready
//   APB          in         metric_select @0, seed_count @4 psel & penable & pwrite
//
// A classify searches min(seed_count, 64) seeds: the back end reads one table entry per cycle
// from its single read port into one shared distance-and-compare pipeline of four stages.
// The front queue holds four items, so input keeps flowing while a pixel is searched
// until the queue is full; the result register holds a label until it is taken.
// Reset clears control and the registers (metric 0, count 25); the seed table is not cleared.
module voronoi_nearest_seed_labeler_core
	import vnsl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// seed_index[5:0], seed_pos_x[21:6], seed_pos_y[37:22], pixel_x[47:38],
	// pixel_y[57:48], zero [63:58]
	input  logic [S_TDATA_W-1:0] s_tdata,
	// mode[0]
	input  logic                 s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// nearest_label[5:0], zero [7:6]
	output logic [M_TDATA_W-1:0] m_tdata,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [APB_AW-1:0]    paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	logic                metric_q;
	logic [COUNT_W-1:0]  seed_count_q;
	logic                cfg_wr;
	logic                q_valid;
	logic                q_pop;
	queue_item_t         q_item;
	logic [LABEL_W-1:0]  label;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_q     <= METRIC_EUCLID;
			seed_count_q <= COUNT_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_METRIC: metric_q     <= pwdata[0];
				REG_COUNT:  seed_count_q <= pwdata[COUNT_W-1:0];
				default:    metric_q     <= metric_q;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (paddr[2])
			REG_METRIC: prdata = {31'b0, metric_q};
			REG_COUNT:  prdata = {(32 - COUNT_W)'(0), seed_count_q};
			default:    prdata = '0;
		endcase
	end

	vnsl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	vnsl_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.metric_select (metric_q),
		.seed_count    (seed_count_q),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_label       (label)
	);

	assign m_tdata = {(M_TDATA_W - LABEL_W)'(0), label};

endmodule

// ----- sim/voronoi_nearest_seed_labeler_core_tb.sv -----
// Self-checking testbench for voronoi_nearest_seed_labeler_core: loads seeds, classifies
// pixels and checks each nearest_label against a behavioral nearest-seed search.
// Depends on vnsl_pkg and the core RTL.
`timescale 1ns / 1ps

module voronoi_nearest_seed_labeler_core_tb;
	import vnsl_pkg::*;

	localparam int DRAIN_CYCLES   = 100;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 400;
	localparam int HOLD_AT        = 150;
	localparam int PHASE_ITEMS    = 235;

	// Seed table and register shadow plus the labels still owed by the block
	class label_scoreboard;
		bit [2*POS_W-1:0]  seed_tbl [MAX_SEED_ENTRIES];
		bit                metric_sel;
		bit [COUNT_W-1:0]  seed_count;
		bit [LABEL_W-1:0]  pending_labels [$];
		int                errors;
		int                labels_checked;

		function new();
			metric_sel     = METRIC_EUCLID;
			seed_count     = COUNT_RESET;
			errors         = 0;
			labels_checked = 0;
		endfunction

		function void set_reg(logic reg_idx, logic [31:0] value);
			if (reg_idx == REG_METRIC)
				metric_sel = value[0];
			else
				seed_count = value[COUNT_W-1:0];
		endfunction

		// Exhaustive search over the active seeds; strict compare keeps the lowest index
		function bit [LABEL_W-1:0] nearest_seed(bit [PIX_W-1:0] pix_x, bit [PIX_W-1:0] pix_y);
			bit [63:0]        px, py, sx, sy, dx, dy, cand_dist, best_dist;
			bit [LABEL_W-1:0] best;
			int               n;
			px        = 64'(pix_x) << FRAC_W;
			py        = 64'(pix_y) << FRAC_W;
			n         = (seed_count > MAX_SEED_ENTRIES) ? MAX_SEED_ENTRIES : int'(seed_count);
			best      = '0;
			// all ones exceeds any reachable distance, so entry 0 always takes the lead
			best_dist = '1;
			for (int i = 0; i < n; i++) begin
				sx   = 64'(seed_tbl[i][POS_W-1:0]);
				sy   = 64'(seed_tbl[i][2*POS_W-1:POS_W]);
				dx   = (px >= sx) ? px - sx : sx - px;
				dy   = (py >= sy) ? py - sy : sy - py;
				cand_dist = (metric_sel == METRIC_EUCLID) ? dx * dx + dy * dy : dx + dy;
				if (cand_dist < best_dist) begin
					best_dist = cand_dist;
					best      = LABEL_W'(i);
				end
			end
			return best;
		endfunction

		// Apply one accepted item: store a seed or queue the label it must produce
		function void note_item(logic mode, logic [S_TDATA_W-1:0] tdata);
			if (mode == MODE_WRITE)
				seed_tbl[tdata[5:0]] = {tdata[37:22], tdata[21:6]};
			else
				pending_labels = {pending_labels, nearest_seed(tdata[47:38], tdata[57:48])};
		endfunction

		function void check_label(logic [M_TDATA_W-1:0] tdata);
			bit [LABEL_W-1:0] want;
			labels_checked++;
			if (pending_labels.size() == 0) begin
				$error("nearest_label: expected none, actual %0d", tdata[LABEL_W-1:0]);
				errors++;
				return;
			end
			want = pending_labels.pop_front();
			if (tdata[LABEL_W-1:0] !== want) begin
				$error("nearest_label: expected %0d, actual %0d", want, tdata[LABEL_W-1:0]);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [APB_AW-1:0]    paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;

	label_scoreboard sb;
	bit              send_burst;
	bit              recv_burst;

	voronoi_nearest_seed_labeler_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	function automatic logic [S_TDATA_W-1:0] pack_item(logic [SEED_IDX_W-1:0] idx,
			logic [POS_W-1:0] x, logic [POS_W-1:0] y, logic [PIX_W-1:0] px,
			logic [PIX_W-1:0] py);
		return {6'd0, py, px, y, x, idx};
	endfunction

	// Offer one item after an idle gap and hold it until accepted
	task automatic send_item(logic mode, logic [S_TDATA_W-1:0] tdata, int gap);
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= tdata;
		s_tuser  <= mode;
		do @(posedge clk); while (!s_tready);
		sb.note_item(mode, tdata);
	endtask

	task automatic write_seed(logic [SEED_IDX_W-1:0] idx, logic [POS_W-1:0] x,
			logic [POS_W-1:0] y, int gap = 0);
		send_item(MODE_WRITE, pack_item(idx, x, y, PIX_W'($urandom), PIX_W'($urandom)), gap);
	endtask

	task automatic classify(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py, int gap = 0);
		send_item(MODE_CLASSIFY,
			pack_item(SEED_IDX_W'($urandom), POS_W'($urandom), POS_W'($urandom), px, py), gap);
	endtask

	// Drop valid and wait until every label is in, then let trailing seed writes retire
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending_labels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Setup then access phase; unused upper bits carry junk
	task automatic apb_write(logic reg_idx, logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'({reg_idx, 2'b00});
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(reg_idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_config(logic metric, logic [COUNT_W-1:0] count);
		wait_idle();
		apb_write(REG_METRIC, {31'($urandom), metric});
		apb_write(REG_COUNT, {25'($urandom), count});
	endtask

	// Take labels with random back-pressure and one long hold-off
	task automatic run_receiver();
		int  gap;
		bit  held;
		held = 1'b0;
		forever begin
			if ($urandom_range(0, 39) == 0)
				recv_burst = ~recv_burst;
			gap = recv_burst ? 0 : $urandom_range(0, 16);
			if (!held && sb.labels_checked == HOLD_AT) begin
				held = 1'b1;
				gap  = HOLD_CYCLES;
			end
			@(negedge clk);
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_label(m_tdata);
		end
	endtask

	// Extremes, duplicate seeds, equal-distance ties and the seed count corner cases
	task automatic run_directed();
		write_seed(0, 16'h0000, 16'h0000);
		write_seed(63, 16'hFFFF, 16'hFFFF);
		write_seed(1, 16'hFFFF, 16'h0000);
		write_seed(2, 16'h0000, 16'hFFFF);
		write_seed(5, 16'(512 << FRAC_W), 16'(512 << FRAC_W));
		write_seed(6, 16'(512 << FRAC_W), 16'(512 << FRAC_W));
		write_seed(8, 16'(300 << FRAC_W), 16'(200 << FRAC_W));
		write_seed(9, 16'(302 << FRAC_W), 16'(200 << FRAC_W));
		classify(0, 0);
		classify(1023, 1023);
		classify(1023, 0);
		classify(0, 1023);
		classify(512, 512);
		classify(301, 200);
		set_config(METRIC_MANHATTAN, 7'd64);
		classify(1023, 1023);
		classify(301, 200);
		classify(512, 512);
		set_config(METRIC_MANHATTAN, 7'd0);
		classify(700, 100);
		set_config(METRIC_EUCLID, 7'd1);
		classify(1023, 1023);
		set_config(METRIC_EUCLID, 7'd127);
		classify(1023, 1023);
		set_config(METRIC_EUCLID, 7'd2);
		classify(1023, 0);
		classify(0, 0);
	endtask

	// Mixed seed writes and classifies, clustered around one spot to provoke close calls
	task automatic run_phase(logic metric, logic [COUNT_W-1:0] count);
		int               cx, cy, span, gap;
		logic [POS_W-1:0] x, y;
		logic [PIX_W-1:0] px, py;
		logic [SEED_IDX_W-1:0] idx;
		set_config(metric, count);
		cx   = $urandom_range(0, IMAGE_DIM - 16);
		cy   = $urandom_range(0, IMAGE_DIM - 16);
		span = (count > MAX_SEED_ENTRIES) ? MAX_SEED_ENTRIES : int'(count);
		if (span == 0)
			span = 1;
		for (int k = 0; k < PHASE_ITEMS; k++) begin
			if ($urandom_range(0, 39) == 0)
				send_burst = ~send_burst;
			gap = send_burst ? 0 : $urandom_range(0, 16);
			if ($urandom_range(0, 9) < 3) begin
				idx = $urandom_range(0, 1) ? SEED_IDX_W'($urandom)
					: SEED_IDX_W'($urandom_range(0, span - 1));
				if ($urandom_range(0, 1)) begin
					x = POS_W'($urandom);
					y = POS_W'($urandom);
				end else begin
					x = POS_W'((cx + $urandom_range(0, 15)) << FRAC_W);
					y = POS_W'((cy + $urandom_range(0, 15)) << FRAC_W);
				end
				write_seed(idx, x, y, gap);
			end else begin
				if ($urandom_range(0, 9) < 6) begin
					px = PIX_W'(cx + $urandom_range(0, 15));
					py = PIX_W'(cy + $urandom_range(0, 15));
				end else begin
					px = PIX_W'($urandom);
					py = PIX_W'($urandom);
				end
				classify(px, py, gap);
			end
		end
	endtask

	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = 1'b0;
		m_tready   = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		send_burst = 1'b0;
		recv_burst = 1'b0;
		sb         = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		fork
			run_receiver();
		join_none
		// fill the whole table so no search ever touches an unwritten entry
		for (int i = 0; i < MAX_SEED_ENTRIES; i++)
			write_seed(SEED_IDX_W'(i), POS_W'($urandom), POS_W'($urandom),
				$urandom_range(0, 3));
		run_directed();
		run_phase(METRIC_EUCLID, 7'd2);
		run_phase(METRIC_MANHATTAN, 7'd64);
		run_phase(METRIC_EUCLID, 7'd64);
		run_phase(METRIC_MANHATTAN, 7'd2);
		run_phase(METRIC_EUCLID, 7'd100);
		run_phase(METRIC_MANHATTAN, 7'd127);
		run_phase(METRIC_EUCLID, COUNT_W'($urandom_range(2, 64)));
		run_phase(METRIC_MANHATTAN, COUNT_W'($urandom_range(2, 64)));
		wait_idle();
		if (sb.pending_labels.size() != 0) begin
			$error("nearest_label: %0d expected labels never arrived", sb.pending_labels.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("PASS voronoi_nearest_seed_labeler_core");
		else
			$display("FAIL voronoi_nearest_seed_labeler_core");
		$finish;
	end

	// Abort when no handshake of any kind completes for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL voronoi_nearest_seed_labeler_core");
		$finish;
	end

endmodule
